FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_PROP_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_PROP_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: src/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// Constants, codes and the byte-sum function of the checksummed command deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccd_pkg;

  // default sizing
  localparam int DEPTH_DEF     = 16;
  localparam int MSG_BYTES_DEF = 8;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int ID_W      = 16;
  localparam int MSG_MAX_W = 64;
  localparam int STATUS_W  = 2;
  localparam int SUM_W     = 12;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_TAIL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_HEAD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP       = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CSUM  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // sum of the two id bytes and the eight message bytes, modulo 4096
  function automatic logic [SUM_W-1:0] byte_sum(input logic [ID_W-1:0] id,
                                                 input logic [MSG_MAX_W-1:0] msg);
    logic [SUM_W-1:0] s;
    s = SUM_W'(id[7:0]) + SUM_W'(id[15:8]);
    for (int b = 0; b < MSG_MAX_W / 8; b++) begin
      s = s + SUM_W'(msg[8*b +: 8]);
    end
    return s;
  endfunction

endpackage

FILE: src/checksummed_command_deque_top.sv
// Checksummed command deque: a ring of DEPTH command entries (id, message and
// byte-sum checksum) with push at tail, push at head and pop from head. After
// reset the block sweeps the entry memory to zero, one entry a cycle, with
// in_ready low; after that it takes one command every cycle unless the read
// stage and the output register are both full and out_ready is low. The
// command word is taken into the read stage, and its result word is loaded
// into the output register once that register is free or being taken. The
// one-entry-per-command memory port sets the rate. There is no full
// detection: pushes into a full ring overwrite, and a pop reports empty only
// when head and tail pointers are equal before wrapping.
// ----------------------------------------------------------------------------
// checksummed_command_deque_top
// Ring-buffer deque of checksummed command entries with a registered memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module checksummed_command_deque_top #(
  parameter int DEPTH     = ccd_pkg::DEPTH_DEF,
  parameter int MSG_BYTES = ccd_pkg::MSG_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ccd_pkg::FUNC_W-1:0]    func,
  input  logic [ccd_pkg::ID_W-1:0]      cmd_id,
  input  logic [ccd_pkg::MSG_MAX_W-1:0] message,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ccd_pkg::STATUS_W-1:0]  status,
  output logic [ccd_pkg::ID_W-1:0]      out_cmd_id,
  output logic [ccd_pkg::MSG_MAX_W-1:0] out_message
);

  import ccd_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int MSG_W  = 8 * MSG_BYTES;
  localparam logic [PTR_W-1:0]  PTR_DEPTH = PTR_W'(DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [MSG_W-1:0] msg;
    logic [SUM_W-1:0] sum;
  } entry_t;

  // clearing sweep
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_idx;

  // ring pointers, range 0 to DEPTH
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] tail_wrap, head_wrap, head_dec;

  // entry memory
  entry_t            mem [DEPTH];
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, new_entry, rd_q;

  // handshake
  logic in_fire, s1_adv;

  // read stage
  logic                s1_valid;
  logic                s1_pop_rd;
  logic [STATUS_W-1:0] s1_status;
  logic                issue_pop_rd;
  logic [STATUS_W-1:0] issue_status;

  // result forming
  logic [SUM_W-1:0]     chk_sum;
  logic [STATUS_W-1:0]  res_status;
  logic [ID_W-1:0]      res_id;
  logic [MSG_MAX_W-1:0] res_msg;

  // stall logic: read stage moves when the output register is free
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !clr_busy && (!s1_valid || !out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // pointer wraps ahead of use
  assign tail_wrap = (tail >= PTR_DEPTH) ? '0 : tail;
  assign head_wrap = (head >= PTR_DEPTH) ? '0 : head;
  assign head_dec  = (head == '0 || head > PTR_DEPTH) ? PTR_LAST : head - PTR_W'(1);

  // entry written by a push, message trimmed to the stored bytes
  assign new_entry.id  = cmd_id;
  assign new_entry.msg = message[MSG_W-1:0];
  assign new_entry.sum = byte_sum(cmd_id, MSG_MAX_W'(message[MSG_W-1:0]));

  // command decode: memory access and pointer update
  // a stored sum always matches its entry, so a pop advances head at issue
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    wr_en        = 1'b0;
    wr_addr      = clr_idx;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = head_wrap[ADDR_W-1:0];
    issue_pop_rd = 1'b0;
    issue_status = STATUS_OK;
    if (clr_busy) begin
      wr_en = 1'b1;
    end else if (in_fire) begin
      unique case (func)
        FUNC_PUSH_TAIL: begin
          wr_en     = 1'b1;
          wr_addr   = tail_wrap[ADDR_W-1:0];
          wr_data   = new_entry;
          tail_next = tail_wrap + PTR_W'(1);
        end
        FUNC_PUSH_HEAD: begin
          wr_en     = 1'b1;
          wr_addr   = head_dec[ADDR_W-1:0];
          wr_data   = new_entry;
          head_next = head_dec;
        end
        FUNC_POP: begin
          if (tail == head) begin
            issue_status = STATUS_EMPTY;
          end else begin
            rd_en        = 1'b1;
            issue_pop_rd = 1'b1;
            head_next    = head_wrap + PTR_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // memory write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy  <= 1'b1;
      clr_idx   <= '0;
      head      <= '0;
      tail      <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + ADDR_W'(1);
        if (clr_idx == ADDR_LAST) begin
          clr_busy <= 1'b0;
        end
      end
      head <= head_next;
      tail <= tail_next;
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checksum recheck of the popped entry
  always_comb begin
    chk_sum    = byte_sum(rd_q.id, MSG_MAX_W'(rd_q.msg));
    res_status = s1_status;
    res_id     = '0;
    res_msg    = '0;
    if (s1_pop_rd) begin
      if (chk_sum != rd_q.sum) begin
        res_status = STATUS_CSUM;
      end else begin
        res_status = STATUS_OK;
        res_id     = rd_q.id;
        res_msg    = MSG_MAX_W'(rd_q.msg);
      end
    end
  end

  // read stage and output payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pop_rd <= issue_pop_rd;
      s1_status <= issue_status;
    end
    if (s1_adv) begin
      status      <= res_status;
      out_cmd_id  <= res_id;
      out_message <= res_msg;
    end
  end

  // pointers never pass DEPTH
  `ASSERT_PROP(a_ptr_range, clk, rst, (head <= PTR_DEPTH) && (tail <= PTR_DEPTH))
  // read data of a waiting pop holds while the read stage waits on the output
  `ASSERT_PROP(a_rd_hold, clk, rst, (s1_valid && s1_pop_rd && !s1_adv) |=> $stable(rd_q))
  // stored sums always match their entries
  `ASSERT_PROP(a_no_csum_err, clk, rst, out_valid |-> (status != STATUS_CSUM))
  // reset restarts the clearing sweep at entry zero
  `ASSERT_PROP_ALWAYS(a_clr_start, clk, rst |=> (clr_busy && clr_idx == '0))

endmodule
